### rtl/fbpa_pkg.sv
// Shared types and constants for the fixed block pool allocator.
// No dependencies; imported by every rtl file of the block.
`default_nettype none

package fbpa_pkg;

  // Page geometry; the port widths below are sized for these
  localparam int POOL_BYTES = 8192;
  localparam int MAX_BLOCKS = 512;

  // Fixed field widths of the ports
  localparam int SZ_W   = 14;   // block size register
  localparam int OFF_W  = 13;   // byte offsets
  localparam int FREE_W = 10;   // reported free block count
  localparam int STAT_W = 2;

  localparam logic [SZ_W-1:0] MIN_BLOCK = SZ_W'(16);
  localparam logic [SZ_W-1:0] RST_BLOCK = SZ_W'(16);

  // Result status codes
  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_EXHAUSTED = 2'd1;
  localparam logic [STAT_W-1:0] ST_BAD_FREE  = 2'd2;

  // Request codes
  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  // Divider status seen by the sequencer
  typedef struct packed {
    logic busy;
    logic done;   // one-cycle pulse, quotient/remainder valid from then on
  } div_stat_t;

endpackage

`default_nettype wire

### rtl/fbpa_div.sv
// Restoring radix-2 divider, one quotient bit per cycle.
// Depends on fbpa_pkg (SZ_W, div_stat_t).
`default_nettype none

module fbpa_div #(
  parameter int DVD_W = 14
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  input  wire logic [DVD_W-1:0]          dividend,
  input  wire logic [fbpa_pkg::SZ_W-1:0] divisor,
  output fbpa_pkg::div_stat_t            stat,
  output logic [DVD_W-1:0]               quotient,
  output logic [fbpa_pkg::SZ_W-1:0]      remainder
);
  import fbpa_pkg::*;

  localparam int CW = $clog2(DVD_W);

  logic [DVD_W-1:0] dvd;
  logic [SZ_W-1:0]  rem;
  logic [SZ_W-1:0]  dvs;
  logic [CW-1:0]    cnt;
  logic             busy;
  logic             done;
  logic [SZ_W:0]    rem_sh;
  logic             ge;

  assign rem_sh = {rem, dvd[DVD_W-1]};
  assign ge     = rem_sh >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= '0;
      dvd  <= dividend;
      dvs  <= divisor;
      rem  <= '0;
    end else if (busy) begin
      rem <= ge ? SZ_W'(rem_sh - {1'b0, dvs}) : rem_sh[SZ_W-1:0];
      dvd <= {dvd[DVD_W-2:0], ge};
      if (cnt == CW'(DVD_W - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end else begin
        cnt  <= cnt + CW'(1);
        done <= 1'b0;
      end
    end else begin
      done <= 1'b0;
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign quotient  = dvd;
  assign remainder = rem;

endmodule

`default_nettype wire

### rtl/fixed_block_pool_allocator.sv
// Fixed-size block pool allocator: LIFO free list of block indices in one page.
// Depends on fbpa_pkg and fbpa_div.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-------------------------------------
//  in      | to block  | in_valid/in_stall  | action, free_offset
//  out     | from block| out_valid/out_stall| status, alloc_offset, blocks_free
//  cfg     | to block  | cfg_we             | cfg_data (block size in bytes)
//
// An alloc reads the link of the head in S_ARD, then pops it in S_ACHK and
// reports its offset (head index times block size). A free uses the
// bit-serial divider to turn the offset into a block index; the remainder
// checks alignment. Reset and every cfg write rebuild the pool: the divider
// divides the page by the block size, then a pass over all MAX_BLOCKS entries
// rewrites the link RAM as an ascending chain; in_stall stays high.
// A stalled result sits in the output register; the next transaction is taken
// meanwhile and only its final step waits for the register to free up.
`default_nettype none

module fixed_block_pool_allocator (
  input  wire logic                        clk,
  input  wire logic                        rst,
  // request channel
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic                        action,
  input  wire logic [fbpa_pkg::OFF_W-1:0]  free_offset,
  // result channel
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [fbpa_pkg::STAT_W-1:0]      status,
  output logic [fbpa_pkg::OFF_W-1:0]       alloc_offset,
  output logic [fbpa_pkg::FREE_W-1:0]      blocks_free,
  // block size register
  input  wire logic                        cfg_we,
  input  wire logic [fbpa_pkg::SZ_W-1:0]   cfg_data
);
  import fbpa_pkg::*;

  // Divider dividend must hold the page size and any byte offset
  localparam int PG_W   = $clog2(POOL_BYTES + 1);
  localparam int DVD_W  = (PG_W > OFF_W) ? PG_W : OFF_W;
  localparam int IDX_W  = $clog2(MAX_BLOCKS);       // link RAM address
  localparam int CNT_W  = $clog2(MAX_BLOCKS + 1);   // counts and links (end marker)
  localparam int CMP_W  = (DVD_W > CNT_W) ? DVD_W : CNT_W;
  localparam int PROD_W = CNT_W + SZ_W;

  typedef enum logic [3:0] {
    S_CNT_GO,    // start page / size division
    S_CNT_WAIT,
    S_CLEAR,     // rewrite link RAM with ascending chain
    S_IDLE,
    S_ARD,       // alloc: read link of head
    S_ACHK,      // alloc: pop and report
    S_FGO,       // free: start offset / size division
    S_FWAIT,
    S_FCHK       // free: check and push
  } state_t;

  state_t state;

  // Config and pool state
  logic [SZ_W-1:0]  block_bytes;
  logic [SZ_W-1:0]  eff_size;
  logic [CNT_W-1:0] block_cnt;
  logic [CNT_W-1:0] head_index;
  logic [CNT_W-1:0] free_total;
  logic [IDX_W-1:0] clr;

  // Latched request
  logic [OFF_W-1:0] off_r;

  // Link RAM
  logic [CNT_W-1:0] next_link [MAX_BLOCKS];
  logic [CNT_W-1:0] rd_link;
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  logic [CNT_W-1:0] mem_wdata;

  // Divider
  logic             div_start;
  logic [DVD_W-1:0] div_dvd;
  div_stat_t        div_stat;
  logic [DVD_W-1:0] div_q;
  logic [SZ_W-1:0]  div_r;

  logic [CMP_W-1:0]  q_ext;
  logic [CMP_W-1:0]  cap_cnt;
  logic [CNT_W-1:0]  new_cnt;
  logic [PROD_W-1:0] prod;
  logic              can_out;
  logic              out_load;
  logic              exhausted;
  logic              bad_free;

  assign eff_size = (block_bytes < MIN_BLOCK) ? MIN_BLOCK : block_bytes;

  assign div_start = (state == S_CNT_GO) || (state == S_FGO);
  assign div_dvd   = (state == S_CNT_GO) ? DVD_W'(POOL_BYTES) : DVD_W'(off_r);

  fbpa_div #(
    .DVD_W(DVD_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (eff_size),
    .stat     (div_stat),
    .quotient (div_q),
    .remainder(div_r)
  );

  // Block count is page / size, capped at the RAM depth
  assign q_ext   = CMP_W'(div_q);
  assign cap_cnt = CMP_W'(MAX_BLOCKS);
  assign new_cnt = (q_ext > cap_cnt) ? CNT_W'(MAX_BLOCKS) : CNT_W'(div_q);

  assign can_out   = !out_valid || !out_stall;
  // Result register loads on the final step of a transaction
  assign out_load  = ((state == S_ACHK) || (state == S_FCHK)) && can_out && !cfg_we;
  assign exhausted = (free_total == '0) || (head_index >= block_cnt);
  // Misaligned, past the last block, or pool already full
  assign bad_free  = (div_r != '0) || (q_ext >= CMP_W'(block_cnt)) ||
                     (free_total >= block_cnt);

  assign prod = PROD_W'(head_index) * PROD_W'(eff_size);

  // Link RAM write port: clearing pass or push on free
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = clr;
    mem_wdata = CNT_W'(clr) + CNT_W'(1);
    if (state == S_CLEAR) begin
      mem_we = 1'b1;
    end else if (state == S_FCHK && out_load && !bad_free) begin
      mem_we    = 1'b1;
      mem_waddr = div_q[IDX_W-1:0];
      mem_wdata = head_index;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      next_link[mem_waddr] <= mem_wdata;
    end
    if (state == S_ARD) begin
      rd_link <= next_link[head_index[IDX_W-1:0]];
    end
  end

  assign in_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CNT_GO;
      block_bytes <= RST_BLOCK;
      out_valid   <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end

      if (cfg_we) begin
        // New block size: rebuild the pool
        block_bytes <= cfg_data;
        state       <= S_CNT_GO;
      end else begin
        unique case (state)
          S_CNT_GO: begin
            state <= S_CNT_WAIT;
          end
          S_CNT_WAIT: begin
            if (div_stat.done) begin
              block_cnt  <= new_cnt;
              free_total <= new_cnt;
              head_index <= '0;
              clr        <= '0;
              state      <= S_CLEAR;
            end
          end
          S_CLEAR: begin
            if (clr == IDX_W'(MAX_BLOCKS - 1)) begin
              state <= S_IDLE;
            end else begin
              clr <= clr + IDX_W'(1);
            end
          end
          S_IDLE: begin
            if (in_valid) begin
              off_r <= free_offset;
              state <= (action == ACT_FREE) ? S_FGO : S_ARD;
            end
          end
          S_ARD: begin
            state <= S_ACHK;
          end
          S_ACHK: begin
            if (can_out) begin
              if (exhausted) begin
                status       <= ST_EXHAUSTED;
                alloc_offset <= '0;
                blocks_free  <= FREE_W'(free_total);
              end else begin
                status       <= ST_OK;
                alloc_offset <= prod[OFF_W-1:0];
                blocks_free  <= FREE_W'(free_total - CNT_W'(1));
                head_index   <= rd_link;
                free_total   <= free_total - CNT_W'(1);
              end
              state <= S_IDLE;
            end
          end
          S_FGO: begin
            state <= S_FWAIT;
          end
          S_FWAIT: begin
            if (div_stat.done) begin
              state <= S_FCHK;
            end
          end
          S_FCHK: begin
            if (can_out) begin
              alloc_offset <= '0;
              if (bad_free) begin
                status      <= ST_BAD_FREE;
                blocks_free <= FREE_W'(free_total);
              end else begin
                status      <= ST_OK;
                blocks_free <= FREE_W'(free_total + CNT_W'(1));
                head_index  <= CNT_W'(div_q);
                free_total  <= free_total + CNT_W'(1);
              end
              state <= S_IDLE;
            end
          end
          default: state <= S_CNT_GO;
        endcase
      end
    end
  end

endmodule

`default_nettype wire

### rtl/fbpa_check.sv
// Port-level checks for the fixed block pool allocator, bound to the top level.
// Depends on fbpa_pkg and fixed_block_pool_allocator.
`default_nettype none

module fbpa_check (
  input wire logic                        clk,
  input wire logic                        rst,
  input wire logic                        in_valid,
  input wire logic                        in_stall,
  input wire logic                        out_valid,
  input wire logic                        out_stall,
  input wire logic [fbpa_pkg::STAT_W-1:0] status,
  input wire logic [fbpa_pkg::OFF_W-1:0]  alloc_offset,
  input wire logic [fbpa_pkg::FREE_W-1:0] blocks_free,
  input wire logic                        cfg_we
);
  import fbpa_pkg::*;

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status) &&
      $stable(alloc_offset) && $stable(blocks_free))
    else $error("stalled result changed");

  // Only successful allocations carry an offset
  a_offset_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> alloc_offset == '0)
    else $error("offset set on failed result");

  // Every transaction is multi-cycle: the block is busy right after accepting
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && !cfg_we |=> in_stall)
    else $error("request taken while previous one in flight");

  // A size write starts a rebuild
  a_rebuild: assert property (@(posedge clk) disable iff (rst)
    cfg_we |=> in_stall)
    else $error("no rebuild after size write");

  // Nothing comes out of reset
  a_reset_quiet: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result valid after reset");

endmodule

bind fixed_block_pool_allocator fbpa_check u_fbpa_check (.*);

`default_nettype wire
